FILE: rtl/mbg_pkg.sv
// Shared types and constants for the backtracking maze generator.
package mbg_pkg;

   localparam int MBG_MAX_SIDE = 256;
   localparam int NUM_DIRS     = 4;

   localparam logic [8:0] SIZE_RESET = 9'd16;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [1:0] DIR_TOP    = 2'd0;
   localparam logic [1:0] DIR_BOTTOM = 2'd1;
   localparam logic [1:0] DIR_EAST   = 2'd2;
   localparam logic [1:0] DIR_WEST   = 2'd3;

   localparam logic [4:0] CELL_VISITED = 5'b00001;
   localparam logic [4:0] CELL_PASS0   = 5'b00010;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DECIDE,
      ST_POP,
      ST_LINK,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/maze_backtracker_generator_core.sv
// Top level of the randomized depth-first maze carver with its cell store and cell stack.
//
//   channel   direction  ports                                    transfer when
//   req       in         req_kind, req_random_value               req_valid & req_ready
//   rsp       out        rsp_cell_x/y, direction, carved, done    rsp_valid & rsp_ready
//   csr       in/out     psel, penable, pwrite, paddr, pwdata      psel & penable
//
// A step item scans the cell store in six slots, reading the four neighbours and the current
// cell, then writes the two cells of a carve, reads the cell stack for a backtrack, or ends
// the walk. A step after the walk has ended goes straight to its result. A start item clears
// the whole cell store, one entry a cycle. Reset is synchronous; the store needs no pass
// after reset, since steps are only walked after a start. A stalled result holds the next
// one back.
module maze_backtracker_generator_core #(
   parameter int MAX_SIDE = mbg_pkg::MBG_MAX_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_random_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_x,
   output logic [7:0]  rsp_cell_y,
   output logic [1:0]  rsp_direction,
   output logic        rsp_carved,
   output logic        rsp_done_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mbg_pkg::*;

   localparam int CELLS   = MAX_SIDE * MAX_SIDE;
   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int DEPTH_W = $clog2(CELLS + 1);
   localparam int ENTRY_W = 2 * COORD_W;

   // Scan slots: the four neighbours, then the current cell, then one slot to take its data.
   localparam logic [2:0] SCAN_CUR  = 3'd4;
   localparam logic [2:0] SCAN_LAST = 3'd5;

   state_type state_ff, state_in;

   logic [8:0] grid_width_ff, grid_height_ff;
   logic [SIDE_W-1:0] eff_w, eff_h;

   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               finished_ff, finished_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [2:0]         scan_cnt_ff, scan_cnt_in;
   logic               inb_prev_ff, inb_prev_in;
   logic [3:0]         free_ff, free_in;
   logic [4:0]         cur_cell_ff, cur_cell_in;
   logic [7:0]         rnd_ff, rnd_in;

   logic [7:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [1:0] res_dir_ff, res_dir_in;
   logic       res_carved_ff, res_carved_in, res_done_ff, res_done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_cell_x_ff, rsp_cell_x_in, rsp_cell_y_ff, rsp_cell_y_in;
   logic [1:0] rsp_direction_ff, rsp_direction_in;
   logic       rsp_carved_ff, rsp_carved_in, rsp_done_ff, rsp_done_in;

   logic [COORD_W-1:0] nbr_x [NUM_DIRS];
   logic [COORD_W-1:0] nbr_y [NUM_DIRS];
   logic [NUM_DIRS-1:0] inb;

   logic [4:0]         store_ff [CELLS];
   logic [4:0]         store_rd_ff;
   logic               store_we, store_re, store_use_clr;
   logic [COORD_W-1:0] store_ax, store_ay;
   logic [ADDR_W-1:0]  store_addr;
   logic [4:0]         store_wdata;

   logic [ENTRY_W-1:0] stack_ff [CELLS];
   logic [ENTRY_W-1:0] stack_rd_ff;
   logic               stack_we, stack_re;
   logic [ADDR_W-1:0]  stack_addr;

   logic [2:0] free_count;
   logic [1:0] pick, sel_dir;

   function automatic logic [1:0] mod3(input logic [7:0] r);
      logic [16:0] prod;
      logic [7:0]  q;
      // Multiply by 171/512 gives the exact quotient for every 8-bit value.
      prod = {9'b0, r} * 17'd171;
      q    = prod[16:9];
      return 2'(r - 8'(q * 8'd3));
   endfunction

   function automatic logic [SIDE_W-1:0] eff_size(input logic [8:0] reg_value);
      if (reg_value == 9'd0) begin
         return SIDE_W'(1);
      end else if (32'(reg_value) > 32'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end else begin
         return SIDE_W'(reg_value);
      end
   endfunction

   // Top and bottom, east and west differ in the low bit only.
   function automatic logic [1:0] opposite(input logic [1:0] d);
      return d ^ 2'b01;
   endfunction

   assign eff_w = eff_size(grid_width_ff);
   assign eff_h = eff_size(grid_height_ff);

   // A shrunken grid can leave the current cell outside the bounds, so both
   // coordinates of every neighbour are tested.
   always_comb begin
      nbr_x[DIR_TOP]    = cur_x_ff;
      nbr_y[DIR_TOP]    = cur_y_ff - COORD_W'(1);
      nbr_x[DIR_BOTTOM] = cur_x_ff;
      nbr_y[DIR_BOTTOM] = cur_y_ff + COORD_W'(1);
      nbr_x[DIR_EAST]   = cur_x_ff + COORD_W'(1);
      nbr_y[DIR_EAST]   = cur_y_ff;
      nbr_x[DIR_WEST]   = cur_x_ff - COORD_W'(1);
      nbr_y[DIR_WEST]   = cur_y_ff;
      inb[DIR_TOP]      = (cur_y_ff != '0) && (SIDE_W'(cur_y_ff) <= eff_h)
                          && (SIDE_W'(cur_x_ff) < eff_w);
      inb[DIR_BOTTOM]   = ((SIDE_W'(cur_y_ff) + SIDE_W'(1)) < eff_h)
                          && (SIDE_W'(cur_x_ff) < eff_w);
      inb[DIR_EAST]     = ((SIDE_W'(cur_x_ff) + SIDE_W'(1)) < eff_w)
                          && (SIDE_W'(cur_y_ff) < eff_h);
      inb[DIR_WEST]     = (cur_x_ff != '0) && (SIDE_W'(cur_x_ff) <= eff_w)
                          && (SIDE_W'(cur_y_ff) < eff_h);
   end

   always_comb begin
      logic [1:0] seen;
      seen       = 2'd0;
      sel_dir    = DIR_TOP;
      free_count = 3'($countones(free_ff));
      case (free_count)
         3'd2:    pick = {1'b0, rnd_ff[0]};
         3'd3:    pick = mod3(rnd_ff);
         3'd4:    pick = rnd_ff[1:0];
         default: pick = 2'd0;
      endcase
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (free_ff[d]) begin
            if (seen == pick) begin
               sel_dir = 2'(d);
            end
            seen = seen + 2'd1;
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      depth_in         = depth_ff;
      finished_in      = finished_ff;
      clr_cnt_in       = clr_cnt_ff;
      scan_cnt_in      = scan_cnt_ff;
      inb_prev_in      = inb_prev_ff;
      free_in          = free_ff;
      cur_cell_in      = cur_cell_ff;
      rnd_in           = rnd_ff;
      res_x_in         = res_x_ff;
      res_y_in         = res_y_ff;
      res_dir_in       = res_dir_ff;
      res_carved_in    = res_carved_ff;
      res_done_in      = res_done_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_cell_x_in    = rsp_cell_x_ff;
      rsp_cell_y_in    = rsp_cell_y_ff;
      rsp_direction_in = rsp_direction_ff;
      rsp_carved_in    = rsp_carved_ff;
      rsp_done_in      = rsp_done_ff;
      store_we         = 1'b0;
      store_re         = 1'b0;
      store_use_clr    = 1'b0;
      store_ax         = cur_x_ff;
      store_ay         = cur_y_ff;
      store_wdata      = '0;
      stack_we         = 1'b0;
      stack_re         = 1'b0;
      stack_addr       = depth_ff[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_x_in      = 8'(cur_x_ff);
               res_y_in      = 8'(cur_y_ff);
               res_dir_in    = DIR_TOP;
               res_carved_in = 1'b0;
               res_done_in   = 1'b0;
               rnd_in        = req_random_value;
               free_in       = '0;
               scan_cnt_in   = '0;
               inb_prev_in   = 1'b0;
               if (req_kind == KIND_START) begin
                  cur_x_in    = '0;
                  cur_y_in    = '0;
                  depth_in    = '0;
                  finished_in = 1'b0;
                  clr_cnt_in  = '0;
                  state_in    = ST_CLEAR;
               end else if (finished_ff) begin
                  res_done_in = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            // The origin cell is written as visited during the sweep itself.
            store_we      = 1'b1;
            store_use_clr = 1'b1;
            store_wdata   = (clr_cnt_ff == '0) ? CELL_VISITED : 5'b0;
            if (clr_cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_RESP;
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == SCAN_CUR) begin
               store_re    = 1'b1;
               inb_prev_in = 1'b1;
            end else if (scan_cnt_ff != SCAN_LAST) begin
               store_ax    = nbr_x[scan_cnt_ff[1:0]];
               store_ay    = nbr_y[scan_cnt_ff[1:0]];
               store_re    = inb[scan_cnt_ff[1:0]];
               inb_prev_in = inb[scan_cnt_ff[1:0]];
            end
            // Read data of the previous slot arrives now.
            if (scan_cnt_ff == SCAN_LAST) begin
               cur_cell_in = store_rd_ff;
               state_in    = ST_DECIDE;
            end else if (scan_cnt_ff != '0) begin
               free_in[2'(scan_cnt_ff - 3'd1)] = inb_prev_ff && !store_rd_ff[0];
            end
            scan_cnt_in = scan_cnt_ff + 3'd1;
         end
         ST_DECIDE: begin
            if (free_count == 3'd0) begin
               if (depth_ff == '0) begin
                  finished_in = 1'b1;
                  res_done_in = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  depth_in   = depth_ff - DEPTH_W'(1);
                  stack_addr = ADDR_W'(depth_ff - DEPTH_W'(1));
                  stack_re   = 1'b1;
                  state_in   = ST_POP;
               end
            end else begin
               if (free_count != 3'd1 && 32'(depth_ff) < CELLS) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + DEPTH_W'(1);
               end
               store_we      = 1'b1;
               store_wdata   = cur_cell_ff | (CELL_PASS0 << sel_dir);
               res_dir_in    = sel_dir;
               res_carved_in = 1'b1;
               state_in      = ST_LINK;
            end
         end
         ST_POP: begin
            cur_x_in = stack_rd_ff[COORD_W-1:0];
            cur_y_in = stack_rd_ff[ENTRY_W-1:COORD_W];
            state_in = ST_RESP;
         end
         ST_LINK: begin
            store_we    = 1'b1;
            store_ax    = nbr_x[res_dir_ff];
            store_ay    = nbr_y[res_dir_ff];
            store_wdata = (CELL_PASS0 << opposite(res_dir_ff)) | CELL_VISITED;
            cur_x_in    = nbr_x[res_dir_ff];
            cur_y_in    = nbr_y[res_dir_ff];
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_cell_x_in    = res_x_ff;
               rsp_cell_y_in    = res_y_ff;
               rsp_direction_in = res_dir_ff;
               rsp_carved_in    = res_carved_ff;
               rsp_done_in      = res_done_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign store_addr = store_use_clr ? clr_cnt_ff
                     : ADDR_W'(ADDR_W'(store_ay) * ADDR_W'(MAX_SIDE) + ADDR_W'(store_ax));

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_addr] <= store_wdata;
      end else if (store_re) begin
         store_rd_ff <= store_ff[store_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ff[stack_addr] <= {cur_y_ff, cur_x_ff};
      end else if (stack_re) begin
         stack_rd_ff <= stack_ff[stack_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         depth_ff     <= '0;
         finished_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         depth_ff     <= depth_in;
         finished_ff  <= finished_in;
         clr_cnt_ff   <= clr_cnt_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inb_prev_ff      <= inb_prev_in;
      free_ff          <= free_in;
      cur_cell_ff      <= cur_cell_in;
      rnd_ff           <= rnd_in;
      res_x_ff         <= res_x_in;
      res_y_ff         <= res_y_in;
      res_dir_ff       <= res_dir_in;
      res_carved_ff    <= res_carved_in;
      res_done_ff      <= res_done_in;
      rsp_cell_x_ff    <= rsp_cell_x_in;
      rsp_cell_y_ff    <= rsp_cell_y_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_carved_ff    <= rsp_carved_in;
      rsp_done_ff      <= rsp_done_in;
   end

   // Register access: bit 2 of the byte address selects the register.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_GRID_WIDTH) begin
            grid_width_ff <= pwdata[8:0];
         end else begin
            grid_height_ff <= pwdata[8:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {23'b0, grid_height_ff}
                                                 : {23'b0, grid_width_ff};
   assign pready = 1'b1;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_x    = rsp_cell_x_ff;
   assign rsp_cell_y    = rsp_cell_y_ff;
   assign rsp_direction = rsp_direction_ff;
   assign rsp_carved    = rsp_carved_ff;
   assign rsp_done_res  = rsp_done_ff;

endmodule

FILE: test/walk_checker.sv
// Checker for the maze carver: predicts each result from the accepted items and compares.
`timescale 1ns / 100ps

module walk_checker #(
   parameter int MAX_SIDE = mbg_pkg::MBG_MAX_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_random_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_cell_x,
   input  logic [7:0]  rsp_cell_y,
   input  logic [1:0]  rsp_direction,
   input  logic        rsp_carved,
   input  logic        rsp_done_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);
   import mbg_pkg::*;

   typedef struct packed {
      logic [7:0] cell_x;
      logic [7:0] cell_y;
      logic [1:0] direction;
      logic       carved;
      logic       done_res;
   } walk_result_type;

   walk_result_type results_due[$];

   // Only the visited bit of each cell matters for what the block reports, so the
   // passage bits are not kept here.
   bit          visited[int unsigned];
   int unsigned path_stack[$];
   int          cur_x;
   int          cur_y;
   bit          walk_ended;
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;

   int error_count = 0;
   int due_count = 0;
   int rsp_count = 0;

   assign mismatches = error_count;
   assign pending = due_count;

   function automatic int clamp_side(input logic [8:0] side);
      if (side == 9'd0) return 1;
      if (side > MAX_SIDE) return MAX_SIDE;
      return int'(side);
   endfunction

   function automatic void advance_walk(input logic kind, input logic [7:0] rnd,
                                        output walk_result_type res);
      int          w;
      int          h;
      int          nx;
      int          ny;
      int          count;
      int          pick;
      int          free_x[4];
      int          free_y[4];
      logic [1:0]  free_dir[4];
      logic [1:0]  dir;
      int unsigned idx;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      count = 0;
      res.cell_x = 8'(cur_x);
      res.cell_y = 8'(cur_y);
      res.direction = DIR_TOP;
      res.carved = 1'b0;
      res.done_res = 1'b0;
      if (kind == KIND_START) begin
         visited.delete();
         path_stack.delete();
         cur_x = 0;
         cur_y = 0;
         visited[0] = 1'b1;
         walk_ended = 1'b0;
      end else if (walk_ended) begin
         res.done_res = 1'b1;
      end else begin
         for (int d = 0; d < NUM_DIRS; d++) begin
            dir = 2'(d);
            nx = cur_x;
            ny = cur_y;
            case (dir)
               DIR_TOP:    ny = ny - 1;
               DIR_BOTTOM: ny = ny + 1;
               DIR_EAST:   nx = nx + 1;
               default:    nx = nx - 1;
            endcase
            if (nx >= 0 && ny >= 0 && nx < w && ny < h &&
                !visited.exists(ny * MAX_SIDE + nx)) begin
               free_x[count] = nx;
               free_y[count] = ny;
               free_dir[count] = dir;
               count++;
            end
         end
         if (count == 0) begin
            if (path_stack.size() == 0) begin
               walk_ended = 1'b1;
               res.done_res = 1'b1;
            end else begin
               idx = path_stack.pop_back();
               cur_x = idx % MAX_SIDE;
               cur_y = idx / MAX_SIDE;
            end
         end else begin
            pick = 0;
            // A cell is saved for backtracking only when there was a real choice.
            if (count > 1) begin
               if (path_stack.size() < MAX_SIDE * MAX_SIDE)
                  path_stack.push_back(cur_y * MAX_SIDE + cur_x);
               pick = rnd % count;
            end
            cur_x = free_x[pick];
            cur_y = free_y[pick];
            visited[cur_y * MAX_SIDE + cur_x] = 1'b1;
            res.direction = free_dir[pick];
            res.carved = 1'b1;
         end
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   rsp_count, name, got, want));
   endtask

   always @(posedge clock) begin
      walk_result_type due;
      logic [8:0]      want_reg;
      if (reset) begin
         results_due.delete();
         visited.delete();
         path_stack.delete();
         cur_x = 0;
         cur_y = 0;
         walk_ended = 1'b1;
         width_reg = SIZE_RESET;
         height_reg = SIZE_RESET;
      end else begin
         if (psel && penable && pready) begin
            want_reg = (paddr[2] == REG_GRID_WIDTH) ? width_reg : height_reg;
            if (pwrite) begin
               if (paddr[2] == REG_GRID_WIDTH) width_reg = pwdata[8:0];
               else height_reg = pwdata[8:0];
            end else if (prdata !== {23'd0, want_reg}) begin
               report_mismatch($sformatf("register read at %0d: got %0h, expected %0h",
                                         paddr, prdata, want_reg));
            end
         end
         if (req_valid && req_ready) begin
            advance_walk(req_kind, req_random_value, due);
            results_due.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         rsp_count));
            end else begin
               due = results_due.pop_front();
               check_field("cell_x", rsp_cell_x, due.cell_x);
               check_field("cell_y", rsp_cell_y, due.cell_y);
               check_field("direction", 8'(rsp_direction), 8'(due.direction));
               check_field("carved", 8'(rsp_carved), 8'(due.carved));
               check_field("done_res", 8'(rsp_done_res), 8'(due.done_res));
            end
            rsp_count++;
         end
      end
      due_count = results_due.size();
   end

endmodule

FILE: test/tb_maze_backtracker_generator_core.sv
// Testbench top for the maze carver: drives walks, grid sizes and stalls, and gives the verdict.
`timescale 1ns / 100ps

module tb_maze_backtracker_generator_core;
   import mbg_pkg::*;

   localparam int MAX_SIDE = MBG_MAX_SIDE;
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int ITEM_TARGET = 1600;
   localparam int START_BUDGET = 9;
   // Every start clears the whole store; every other item may meet the longest gap and stall.
   localparam int CYCLE_LIMIT = 4 * (START_BUDGET * (CELLS + 40) + (ITEM_TARGET + 400) * 80);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_STEP;
   logic [7:0]  req_random_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_cell_x;
   logic [7:0]  rsp_cell_y;
   logic [1:0]  rsp_direction;
   logic        rsp_carved;
   logic        rsp_done_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int pending;
   int cycles = 0;
   int walks_ended = 0;
   int ended_mark = 0;
   int useful = 0;
   int starts_left = 0;
   int ready_hold = 0;
   bit quiet = 1'b0;
   bit rsp_took = 1'b0;

   maze_backtracker_generator_core #(.MAX_SIDE(MAX_SIDE)) u_top (.*);

   walk_checker #(.MAX_SIDE(MAX_SIDE)) u_walk_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_took <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready && rsp_done_res) walks_ended <= walks_ended + 1;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The receiver draws a fresh stall after every result transfer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) ready_hold = quiet ? 0 : $urandom_range(0, 13);
         if (ready_hold > 0) begin
            rsp_ready <= 1'b0;
            ready_hold = ready_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic bit walk_over();
      return walks_ended != ended_mark;
   endfunction

   function automatic logic [8:0] pick_side();
      case ($urandom_range(0, 19))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'(MAX_SIDE);
         3:       return 9'($urandom_range(MAX_SIDE + 1, 511));
         4, 5:    return 9'($urandom_range(9, 40));
         default: return 9'($urandom_range(2, 8));
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_random_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Writes one size register and reads it back; the checker compares the read data.
   task automatic write_reg(input logic which, input logic [8:0] side);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {which, 2'b00};
      pwdata <= {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, side};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_grid(input logic [8:0] w, input logic [8:0] h);
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
   endtask

   task automatic begin_walk();
      drain();
      ended_mark = walks_ended;
      send_item(KIND_START, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_steps(input int n);
      for (int i = 0; i < n && !walk_over(); i++) begin
         send_item(KIND_STEP, 8'($urandom_range(0, 255)));
         useful++;
      end
      // Up to two steps after the end of a walk must leave everything as it is.
      if (walk_over()) repeat ($urandom_range(0, 2)) send_item(KIND_STEP, 8'($urandom));
   endtask

   // A one-cell-wide grid walks straight to the far edge, reaching the top coordinate.
   task automatic run_corridor(input logic [8:0] w, input logic [8:0] h);
      drain();
      set_grid(w, h);
      begin_walk();
      repeat (MAX_SIDE + 1) send_item(KIND_STEP, 8'($urandom_range(0, 255)));
      useful += MAX_SIDE;
   endtask

   initial begin
      logic [7:0] probe_values[8];
      probe_values = '{8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h0F, 8'hF0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Nothing has been started yet, so this step only reports the idle walk.
      send_item(KIND_STEP, 8'hFF);
      drain();
      set_grid(9'd0, 9'd0);
      begin_walk();

      // On a 2x2 grid with pick zero the walk goes bottom, east, then top.
      drain();
      set_grid(9'd2, 9'd2);
      repeat (3) send_item(KIND_STEP, 8'h00);

      // Growing to 3x3 mid-walk opens east, two bottoms and two wests, then one
      // backtrack, the end of the walk and an idle step.
      drain();
      set_grid(9'd3, 9'd3);
      foreach (probe_values[i]) send_item(KIND_STEP, probe_values[i]);

      run_corridor(9'(MAX_SIDE), 9'd1);
      run_corridor(9'd1, 9'd511);

      starts_left = START_BUDGET - 3;
      while (useful < ITEM_TARGET) begin
         if (walk_over() || (starts_left > 1 && $urandom_range(0, 11) == 0)) begin
            if (starts_left == 0) begin
               // With every start used, the remaining items are steps on the ended walk.
               send_item(KIND_STEP, 8'($urandom));
               useful++;
               continue;
            end
            drain();
            set_grid(pick_side(), pick_side());
            begin_walk();
            starts_left--;
         end
         quiet = ($urandom_range(0, 4) == 0);
         run_steps($urandom_range(4, 40));
         // The grid changes only once every result of the chunk has come back.
         drain();
         case ($urandom_range(0, 3))
            0:       write_reg(REG_GRID_WIDTH, pick_side());
            1:       write_reg(REG_GRID_HEIGHT, pick_side());
            2:       set_grid(pick_side(), pick_side());
            default: ;
         endcase
      end
      quiet = 1'b0;

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
